@@ hdl/edc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edc_pkg
// Shared types and constants for the elastic disc collision engine.
// ----------------------------------------------------------------------------
package edc_pkg;

  // Masses are plain unsigned integers of a fixed width.
  localparam int MASS_W = 16;

  // The mass sum carries one extra bit.
  localparam int MSUM_W = MASS_W + 1;

  typedef logic [MASS_W-1:0] mass_t;
  typedef logic [MSUM_W-1:0] msum_t;

endpackage
`default_nettype wire

@@ hdl/edc_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edc_div
// Pipelined signed divider with round-to-nearest (ties away from zero).
// Several numerator lanes share one unsigned divisor. One quotient bit is
// resolved per stage, so a new item can enter in every cycle.
// ----------------------------------------------------------------------------
module edc_div #(
  parameter int LANES = 2,
  parameter int NW    = 53,
  parameter int DW    = 17,
  parameter int SW    = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_vld,
  input  wire logic [LANES*NW-1:0]     num_i,
  input  wire logic [DW-1:0]           den_i,
  input  wire logic [SW-1:0]           side_i,
  output logic                         out_vld,
  output logic [LANES*(NW+1)-1:0]      quo_o,
  output logic [SW-1:0]                side_o
);

  // Stage registers: index 0 is the loaded operand, index NW the finished one.
  logic [NW:0]        vld_r;
  logic [DW-1:0]      den_r  [NW+1];
  logic [SW-1:0]      side_r [NW+1];
  logic [NW-1:0]      qn_r   [LANES][NW+1];
  logic [DW-1:0]      rem_r  [LANES][NW+1];
  logic               neg_r  [LANES][NW+1];

  logic [NW-1:0]      load_a   [LANES];
  logic               load_neg [LANES];
  logic [DW-1:0]      rem_nxt  [LANES][NW];
  logic [NW-1:0]      qn_nxt   [LANES][NW];
  logic [LANES*(NW+1)-1:0] quo_nxt;

  // Load: magnitude of the numerator plus half the divisor for rounding.
  always_comb begin
    logic signed [NW-1:0] n;
    logic [NW-1:0]        mag;
    for (int l = 0; l < LANES; l++) begin
      n           = signed'(num_i[l*NW +: NW]);
      mag         = n[NW-1] ? NW'(-n) : NW'(n);
      load_a[l]   = mag + NW'(den_i >> 1);
      load_neg[l] = n[NW-1];
    end
  end

  // Restoring division steps, one quotient bit per stage.
  always_comb begin
    logic [DW:0] trial;
    logic        ge;
    for (int l = 0; l < LANES; l++) begin
      for (int j = 0; j < NW; j++) begin
        trial         = {rem_r[l][j], qn_r[l][j][NW-1]};
        ge            = trial >= {1'b0, den_r[j]};
        rem_nxt[l][j] = ge ? DW'(trial - {1'b0, den_r[j]}) : trial[DW-1:0];
        qn_nxt[l][j]  = {qn_r[l][j][NW-2:0], ge};
      end
    end
  end

  // Apply the sign to the finished magnitude.
  always_comb begin
    logic [NW:0] q;
    for (int l = 0; l < LANES; l++) begin
      q = {1'b0, qn_r[l][NW]};
      quo_nxt[l*(NW+1) +: (NW+1)] = neg_r[l][NW] ? (NW+1)'(-q) : q;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_vld <= 1'b0;
    end else begin
      vld_r   <= {vld_r[NW-1:0], in_vld};
      out_vld <= vld_r[NW];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    den_r[0]  <= den_i;
    side_r[0] <= side_i;
    for (int l = 0; l < LANES; l++) begin
      qn_r[l][0]  <= load_a[l];
      rem_r[l][0] <= '0;
      neg_r[l][0] <= load_neg[l];
    end
    for (int j = 0; j < NW; j++) begin
      den_r[j+1]  <= den_r[j];
      side_r[j+1] <= side_r[j];
      for (int l = 0; l < LANES; l++) begin
        qn_r[l][j+1]  <= qn_nxt[l][j];
        rem_r[l][j+1] <= rem_nxt[l][j];
        neg_r[l][j+1] <= neg_r[l][j];
      end
    end
    quo_o  <= quo_nxt;
    side_o <= side_r[NW];
  end

endmodule
`default_nettype wire

@@ hdl/elastic_disc_collision.sv @@
`default_nettype none
// Most of the pipeline from start to out_valid lies in the two bit-per-stage
// dividers.
// Throughput: one item per cycle; busy is always low and out_valid is a
// one-cycle strobe that the receiver cannot hold off.
// Reset: synchronous active-low rst_n clears all valid bits; payload is not
// cleared.
// ----------------------------------------------------------------------------
// elastic_disc_collision
// Contact test and elastic velocity exchange for one pair of discs, fully
// pipelined. Projections onto the center line use division by |d|^2.
// ----------------------------------------------------------------------------
module elastic_disc_collision #(
  parameter int POS_WIDTH = 16,
  parameter int VEL_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [POS_WIDTH-1:0] in_first_x,
  input  wire logic signed [POS_WIDTH-1:0] in_first_y,
  input  wire logic signed [POS_WIDTH-1:0] in_second_x,
  input  wire logic signed [POS_WIDTH-1:0] in_second_y,
  input  wire logic signed [VEL_WIDTH-1:0] in_first_vx,
  input  wire logic signed [VEL_WIDTH-1:0] in_first_vy,
  input  wire logic signed [VEL_WIDTH-1:0] in_second_vx,
  input  wire logic signed [VEL_WIDTH-1:0] in_second_vy,
  input  wire logic [POS_WIDTH-1:0]        in_first_radius,
  input  wire logic [POS_WIDTH-1:0]        in_second_radius,
  input  wire edc_pkg::mass_t              in_first_mass,
  input  wire edc_pkg::mass_t              in_second_mass,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic signed [VEL_WIDTH-1:0]      out_new_first_vx,
  output logic signed [VEL_WIDTH-1:0]      out_new_first_vy,
  output logic signed [VEL_WIDTH-1:0]      out_new_second_vx,
  output logic signed [VEL_WIDTH-1:0]      out_new_second_vy,
  output logic                             out_clipped
);

  import edc_pkg::*;

  localparam int P    = POS_WIDTH;
  localparam int V    = VEL_WIDTH;
  localparam int DSQW = 2*P + 1;          // |d|^2
  localparam int RSQW = 2*P + 2;          // (r1+r2)^2
  localparam int PRW  = P + 1 + V;        // one dot product term
  localparam int SW_  = P + V + 2;        // dot product
  localparam int DFW  = P + V + 3;        // dot product difference
  localparam int NW1  = P + V + 21;       // 2*m*diff
  localparam int KW   = P + V + 4;        // rounded impulse term
  localparam int NW2  = P + 1 + KW;       // d component times impulse
  localparam int QW   = KW + 1;           // projected velocity change
  localparam int SUMW = KW + 2;

  typedef struct packed {
    logic                upd;
    logic                hit;
    logic [DSQW-1:0]     dsq;
    logic signed [P:0]   dx;
    logic signed [P:0]   dy;
    logic signed [V-1:0] v1x;
    logic signed [V-1:0] v1y;
    logic signed [V-1:0] v2x;
    logic signed [V-1:0] v2y;
  } sb1_t;

  typedef struct packed {
    logic                upd;
    logic                hit;
    logic signed [V-1:0] v1x;
    logic signed [V-1:0] v1y;
    logic signed [V-1:0] v2x;
    logic signed [V-1:0] v2y;
  } sb2_t;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Stage 1: capture the item.
  logic                s1_vld_r;
  logic signed [P-1:0] s1_p1x_r, s1_p1y_r, s1_p2x_r, s1_p2y_r;
  logic signed [V-1:0] s1_v1x_r, s1_v1y_r, s1_v2x_r, s1_v2y_r;
  logic [P-1:0]        s1_r1_r, s1_r2_r;
  mass_t               s1_m1_r, s1_m2_r;

  always_ff @(posedge clk) begin
    s1_p1x_r <= in_first_x;
    s1_p1y_r <= in_first_y;
    s1_p2x_r <= in_second_x;
    s1_p2y_r <= in_second_y;
    s1_v1x_r <= in_first_vx;
    s1_v1y_r <= in_first_vy;
    s1_v2x_r <= in_second_vx;
    s1_v2y_r <= in_second_vy;
    s1_r1_r  <= in_first_radius;
    s1_r2_r  <= in_second_radius;
    s1_m1_r  <= in_first_mass;
    s1_m2_r  <= in_second_mass;
  end

  // Stage 2: center offset, radius sum and mass sum.
  logic                s2_vld_r;
  logic signed [P:0]   s2_dx_r, s2_dy_r;
  logic [P:0]          s2_rs_r;
  logic signed [V-1:0] s2_v1x_r, s2_v1y_r, s2_v2x_r, s2_v2y_r;
  mass_t               s2_m1_r, s2_m2_r;
  msum_t               s2_ms_r;

  always_ff @(posedge clk) begin
    s2_dx_r  <= (P+1)'(s1_p2x_r) - (P+1)'(s1_p1x_r);
    s2_dy_r  <= (P+1)'(s1_p2y_r) - (P+1)'(s1_p1y_r);
    s2_rs_r  <= {1'b0, s1_r1_r} + {1'b0, s1_r2_r};
    s2_ms_r  <= {1'b0, s1_m1_r} + {1'b0, s1_m2_r};
    s2_v1x_r <= s1_v1x_r;
    s2_v1y_r <= s1_v1y_r;
    s2_v2x_r <= s1_v2x_r;
    s2_v2y_r <= s1_v2y_r;
    s2_m1_r  <= s1_m1_r;
    s2_m2_r  <= s1_m2_r;
  end

  // Stage 3: squares and dot product terms.
  logic                s3_vld_r;
  logic signed [RSQW-1:0] s3_dxx_r, s3_dyy_r;
  logic [RSQW-1:0]     s3_rsq_r;
  logic signed [PRW-1:0] s3_a1_r, s3_b1_r, s3_a2_r, s3_b2_r;
  logic signed [P:0]   s3_dx_r, s3_dy_r;
  logic signed [V-1:0] s3_v1x_r, s3_v1y_r, s3_v2x_r, s3_v2y_r;
  mass_t               s3_m1_r, s3_m2_r;
  msum_t               s3_ms_r;

  always_ff @(posedge clk) begin
    s3_dxx_r <= RSQW'(s2_dx_r * s2_dx_r);
    s3_dyy_r <= RSQW'(s2_dy_r * s2_dy_r);
    s3_rsq_r <= RSQW'(s2_rs_r * s2_rs_r);
    s3_a1_r  <= PRW'(PRW'(s2_dx_r) * PRW'(s2_v1x_r));
    s3_b1_r  <= PRW'(PRW'(s2_dy_r) * PRW'(s2_v1y_r));
    s3_a2_r  <= PRW'(PRW'(s2_dx_r) * PRW'(s2_v2x_r));
    s3_b2_r  <= PRW'(PRW'(s2_dy_r) * PRW'(s2_v2y_r));
    s3_dx_r  <= s2_dx_r;
    s3_dy_r  <= s2_dy_r;
    s3_v1x_r <= s2_v1x_r;
    s3_v1y_r <= s2_v1y_r;
    s3_v2x_r <= s2_v2x_r;
    s3_v2y_r <= s2_v2y_r;
    s3_m1_r  <= s2_m1_r;
    s3_m2_r  <= s2_m2_r;
    s3_ms_r  <= s2_ms_r;
  end

  // Stage 4: |d|^2, contact test, update decision and the two dot products.
  logic                s4_vld_r;
  logic [RSQW-1:0]     s4_dsq_w;
  logic                s4_hit_w;
  logic signed [SW_-1:0] s4_s1_r, s4_s2_r;
  sb1_t                s4_sb_r;
  mass_t               s4_m1_r, s4_m2_r;
  msum_t               s4_ms_r;

  assign s4_dsq_w = RSQW'(s3_dxx_r) + RSQW'(s3_dyy_r);
  assign s4_hit_w = s3_rsq_r >= s4_dsq_w;

  always_ff @(posedge clk) begin
    s4_s1_r  <= SW_'(s3_a1_r) + SW_'(s3_b1_r);
    s4_s2_r  <= SW_'(s3_a2_r) + SW_'(s3_b2_r);
    s4_sb_r.upd <= s4_hit_w && (s4_dsq_w != '0) && (s3_ms_r != '0);
    s4_sb_r.hit <= s4_hit_w;
    s4_sb_r.dsq <= s4_dsq_w[DSQW-1:0];
    s4_sb_r.dx  <= s3_dx_r;
    s4_sb_r.dy  <= s3_dy_r;
    s4_sb_r.v1x <= s3_v1x_r;
    s4_sb_r.v1y <= s3_v1y_r;
    s4_sb_r.v2x <= s3_v2x_r;
    s4_sb_r.v2y <= s3_v2y_r;
    s4_m1_r  <= s3_m1_r;
    s4_m2_r  <= s3_m2_r;
    s4_ms_r  <= s3_ms_r;
  end

  // Stage 5: dot product differences.
  logic                s5_vld_r;
  logic signed [DFW-1:0] s5_d12_r, s5_d21_r;
  sb1_t                s5_sb_r;
  mass_t               s5_m1_r, s5_m2_r;
  msum_t               s5_ms_r;

  always_ff @(posedge clk) begin
    s5_d12_r <= DFW'(s4_s2_r) - DFW'(s4_s1_r);
    s5_d21_r <= DFW'(s4_s1_r) - DFW'(s4_s2_r);
    s5_sb_r  <= s4_sb_r;
    s5_m1_r  <= s4_m1_r;
    s5_m2_r  <= s4_m2_r;
    s5_ms_r  <= s4_ms_r;
  end

  // Stage 6: mass-weighted momentum numerators.
  logic                s6_vld_r;
  logic signed [NW1-1:0] s6_n1_r, s6_n2_r;
  sb1_t                s6_sb_r;
  msum_t               s6_ms_r;

  always_ff @(posedge clk) begin
    s6_n1_r  <= {(NW1-1)'(signed'({1'b0, s5_m2_r}) * s5_d12_r), 1'b0};
    s6_n2_r  <= {(NW1-1)'(signed'({1'b0, s5_m1_r}) * s5_d21_r), 1'b0};
    s6_sb_r  <= s5_sb_r;
    s6_ms_r  <= s5_ms_r;
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  // Divide by the mass sum: impulse terms k1 and k2.
  logic                  d1_vld;
  logic [2*(NW1+1)-1:0]  d1_quo;
  sb1_t                  d1_sb;

  edc_div #(
    .LANES (2),
    .NW    (NW1),
    .DW    (MSUM_W),
    .SW    ($bits(sb1_t))
  ) u_div_mass (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s6_vld_r),
    .num_i   ({s6_n2_r, s6_n1_r}),
    .den_i   (s6_ms_r),
    .side_i  (s6_sb_r),
    .out_vld (d1_vld),
    .quo_o   (d1_quo),
    .side_o  (d1_sb)
  );

  // Stage 7: scale the center offset by each impulse term.
  logic                  s7_vld_r;
  logic signed [KW-1:0]  k1_w, k2_w;
  logic signed [NW2-1:0] s7_x1_r, s7_y1_r, s7_x2_r, s7_y2_r;
  logic [DSQW-1:0]       s7_dsq_r;
  sb2_t                  s7_sb_r;

  assign k1_w = signed'(d1_quo[KW-1:0]);
  assign k2_w = signed'(d1_quo[(NW1+1) +: KW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s7_x1_r  <= NW2'(d1_sb.dx * k1_w);
    s7_y1_r  <= NW2'(d1_sb.dy * k1_w);
    s7_x2_r  <= NW2'(d1_sb.dx * k2_w);
    s7_y2_r  <= NW2'(d1_sb.dy * k2_w);
    s7_dsq_r <= d1_sb.dsq;
    s7_sb_r.upd <= d1_sb.upd;
    s7_sb_r.hit <= d1_sb.hit;
    s7_sb_r.v1x <= d1_sb.v1x;
    s7_sb_r.v1y <= d1_sb.v1y;
    s7_sb_r.v2x <= d1_sb.v2x;
    s7_sb_r.v2y <= d1_sb.v2y;
  end

  // Divide by |d|^2: velocity changes along the center line.
  logic                  d2_vld;
  logic [4*(NW2+1)-1:0]  d2_quo;
  sb2_t                  d2_sb;

  edc_div #(
    .LANES (4),
    .NW    (NW2),
    .DW    (DSQW),
    .SW    ($bits(sb2_t))
  ) u_div_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s7_vld_r),
    .num_i   ({s7_y2_r, s7_x2_r, s7_y1_r, s7_x1_r}),
    .den_i   (s7_dsq_r),
    .side_i  (s7_sb_r),
    .out_vld (d2_vld),
    .quo_o   (d2_quo),
    .side_o  (d2_sb)
  );

  // Output stage: add the changes, saturate and select.
  logic signed [V-1:0] vin  [4];
  logic signed [V-1:0] vout [4];
  logic [3:0]          sat_w;

  assign vin[0] = d2_sb.v1x;
  assign vin[1] = d2_sb.v1y;
  assign vin[2] = d2_sb.v2x;
  assign vin[3] = d2_sb.v2y;

  always_comb begin
    logic signed [QW-1:0]   q;
    logic signed [SUMW-1:0] sum;
    for (int c = 0; c < 4; c++) begin
      q   = signed'(d2_quo[c*(NW2+1) +: QW]);
      sum = SUMW'(vin[c]) + SUMW'(q);
      sat_w[c] = (sum[SUMW-1:V-1] != '0) && (sum[SUMW-1:V-1] != '1);
      if (!d2_sb.upd) begin
        vout[c] = vin[c];
      end else if (sat_w[c]) begin
        vout[c] = sum[SUMW-1] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}};
      end else begin
        vout[c] = sum[V-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_hit           <= d2_sb.hit;
    out_new_first_vx  <= vout[0];
    out_new_first_vy  <= vout[1];
    out_new_second_vx <= vout[2];
    out_new_second_vy <= vout[3];
    out_clipped       <= d2_sb.upd && (sat_w != '0);
  end

`ifndef ASSERT_OFF
  // Saturation can only happen on a resolved contact.
  a_clip_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_hit)
    else $error("clipped set without contact");

  // An update is only applied to a pair that is in contact.
  a_upd_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    d2_vld && d2_sb.upd |-> d2_sb.hit)
    else $error("velocity update without contact");

  // Without an update the velocities pass through unchanged.
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    d2_vld && !d2_sb.upd |=> out_new_first_vx == $past(d2_sb.v1x)
      && out_new_second_vy == $past(d2_sb.v2y) && !out_clipped)
    else $error("velocities changed without an update");
`endif

endmodule
`default_nettype wire
